@@ hw/rtl/afed_pkg.sv @@
// ----------------------------------------------------------------------------
// afed_pkg
// Shared constants for the alarm frame edge event decoder: captured byte
// positions, frame header and trailer codes, configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package afed_pkg;

    // configuration register indexes
    localparam logic CFG_ADAS_DEVICE = 1'b0;
    localparam logic CFG_DSM_DEVICE  = 1'b1;

    // only these byte positions of a frame are ever looked at
    localparam int CAP_N = 16;
    typedef logic [5:0] cap_pos_t;
    localparam cap_pos_t CAP_POS [CAP_N] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd8, 6'd10, 6'd11,
        6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd29, 6'd36, 6'd45
    };

    // slot of each position in CAP_POS
    localparam int CI_B0  = 0;
    localparam int CI_B1  = 1;
    localparam int CI_B2  = 2;
    localparam int CI_B3  = 3;
    localparam int CI_B4  = 4;
    localparam int CI_B8  = 5;
    localparam int CI_B10 = 6;
    localparam int CI_B11 = 7;
    localparam int CI_B19 = 8;
    localparam int CI_B20 = 9;
    localparam int CI_B21 = 10;
    localparam int CI_B22 = 11;
    localparam int CI_B23 = 12;
    localparam int CI_B29 = 13;
    localparam int CI_B36 = 14;
    localparam int CI_B45 = 15;

    // camera alarm fields, in event order
    localparam int ADAS_FIELDS = 7;
    localparam int ADAS_CI [ADAS_FIELDS] = '{
        CI_B10, CI_B11, CI_B19, CI_B20, CI_B21, CI_B22, CI_B23
    };

    // frame lengths
    localparam int LEN_ADAS    = 37;
    localparam int LEN_LITE    = 5;
    localparam int LEN_STD_MIN = 46;
    localparam int LEN_STD_END = 92;

    // header, trailer and field codes
    localparam logic [7:0] HDR_START = 8'h5b;
    localparam logic [7:0] ID_ADAS   = 8'h49;
    localparam logic [7:0] TRL_ADAS  = 8'h5d;
    localparam logic [7:0] ID_DSM    = 8'h79;
    localparam logic [7:0] ID_LITE   = 8'h42;
    localparam logic [7:0] TRL_DSM   = 8'h5f;
    localparam logic [7:0] VAL_TWO   = 8'h02;
    localparam logic [7:0] VAL_ONE   = 8'h01;
    localparam logic [7:0] VAL_ZERO  = 8'h00;

    // event mask, bit k-1 means event k
    localparam int EV_N = 8;
    typedef logic [EV_N-1:0] ev_mask_t;

endpackage

`default_nettype wire

@@ hw/rtl/alarm_frame_edge_event_decoder.sv @@
// path: last byte -> input register -> event mask register, which drives m_*
// throughput: one byte per cycle unless stalled; n events of a frame go out one by one,
//   and the next burst's closing byte waits in the input register until the last one goes
// reset: async active low; clears byte count, previous-field stores, pending events,
//   and loads device codes 1 and 2
// ----------------------------------------------------------------------------
// alarm_frame_edge_event_decoder
// Captures bytes of each receive burst, classifies the frame at burst end and
// emits one event per newly raised alarm.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_frame_edge_event_decoder #(
    parameter int BURST_LIMIT = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    // received bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // burst_end
    // events
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] device_code, [11:8] event_code, [15:12] zero
    output logic             m_tlast    // last_event
);

    localparam int CNT_W = $clog2(BURST_LIMIT + 1);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_end_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [7:0]             cap_reg [afed_pkg::CAP_N];
    logic [7:0]             adas_prev_reg [afed_pkg::ADAS_FIELDS];
    logic [7:0]             dsm_prev_reg [3];
    logic [7:0]             adas_code_reg, dsm_code_reg;
    afed_pkg::ev_mask_t     mask_reg, mask_next;
    logic [7:0]             dev_reg, dev_next;

    logic [7:0]             v [afed_pkg::CAP_N];
    logic [CNT_W-1:0]       len;
    logic                   close, proc, out_take, last_one, ev_free;
    logic                   adas_hit, lite_hit, std_hit;
    afed_pkg::ev_mask_t     ev_mask, mask_rest;
    logic [7:0]             r3, r8;
    logic [3:0]             ev_code;

    // view of captured bytes including the one being processed
    always_comb
    begin
        for (int i = 0; i < afed_pkg::CAP_N; i++)
        begin
            v[i] = (cnt_reg == CNT_W'(afed_pkg::CAP_POS[i])) ? in_byte_reg : cap_reg[i];
        end
    end

    assign len   = cnt_reg + CNT_W'(1);
    assign close = in_end_reg || (len == CNT_W'(BURST_LIMIT));

    always_comb
    begin
        adas_hit = (len == CNT_W'(afed_pkg::LEN_ADAS))
                && (v[afed_pkg::CI_B0] == afed_pkg::HDR_START)
                && (v[afed_pkg::CI_B1] == afed_pkg::ID_ADAS)
                && (v[afed_pkg::CI_B36] == afed_pkg::TRL_ADAS);
        lite_hit = (len == CNT_W'(afed_pkg::LEN_LITE))
                && (v[afed_pkg::CI_B0] == afed_pkg::HDR_START)
                && (v[afed_pkg::CI_B1] == afed_pkg::ID_DSM)
                && (v[afed_pkg::CI_B2] == afed_pkg::ID_LITE)
                && (v[afed_pkg::CI_B4] == afed_pkg::TRL_DSM);
        std_hit  = (len >= CNT_W'(afed_pkg::LEN_STD_MIN))
                && (len < CNT_W'(afed_pkg::LEN_STD_END))
                && (v[afed_pkg::CI_B0] == afed_pkg::HDR_START)
                && (v[afed_pkg::CI_B1] == afed_pkg::ID_DSM)
                && (v[afed_pkg::CI_B45] == afed_pkg::TRL_DSM);

        r3 = v[afed_pkg::CI_B3] & ~dsm_prev_reg[0];
        r8 = v[afed_pkg::CI_B8] & ~dsm_prev_reg[1];

        ev_mask = '0;
        if (adas_hit)
        begin
            for (int i = 0; i < 5; i++)
            begin
                ev_mask[i] = (v[afed_pkg::ADAS_CI[i]] == afed_pkg::VAL_TWO)
                          && (adas_prev_reg[i] != afed_pkg::VAL_TWO);
            end
            ev_mask[5] = ((v[afed_pkg::CI_B22] == afed_pkg::VAL_ONE)
                       || (v[afed_pkg::CI_B22] == afed_pkg::VAL_TWO))
                      && (adas_prev_reg[5] == afed_pkg::VAL_ZERO);
            ev_mask[6] = (v[afed_pkg::CI_B23] == afed_pkg::VAL_ONE)
                      && (adas_prev_reg[6] != afed_pkg::VAL_ONE);
            ev_mask[7] = (v[afed_pkg::CI_B23] == afed_pkg::VAL_TWO)
                      && (adas_prev_reg[6] != afed_pkg::VAL_TWO);
        end
        else if (lite_hit)
        begin
            // lite frame has no event 6
            ev_mask = {r3[6], r3[5], 1'b0, r3[4:0]};
        end
        else if (std_hit)
        begin
            ev_mask = {v[afed_pkg::CI_B29][4] & ~dsm_prev_reg[2][4],
                       v[afed_pkg::CI_B29][0] & ~dsm_prev_reg[2][0],
                       r8[5:0]};
        end
    end

    // output side
    assign mask_rest = mask_reg & (mask_reg - afed_pkg::ev_mask_t'(1));
    assign last_one  = (mask_rest == '0);
    assign m_tvalid  = (mask_reg != '0);
    assign out_take  = m_tvalid && m_tready;
    assign ev_free   = !m_tvalid || (out_take && last_one);

    always_comb
    begin
        ev_code = '0;
        for (int i = afed_pkg::EV_N - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                ev_code = 4'(i + 1);
            end
        end
    end

    assign m_tdata = {4'b0000, ev_code, dev_reg};
    assign m_tlast = last_one;

    // a closing byte waits until the event register is free
    assign proc     = in_valid_reg && (!close || ev_free);
    assign s_tready = !in_valid_reg || proc;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end

        cnt_next = cnt_reg;
        if (proc)
        begin
            cnt_next = close ? '0 : len;
        end

        mask_next = mask_reg;
        dev_next  = dev_reg;
        if (proc && close)
        begin
            mask_next = ev_mask;
            dev_next  = adas_hit ? adas_code_reg : dsm_code_reg;
        end
        else if (out_take)
        begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            adas_code_reg <= 8'd1;
            dsm_code_reg  <= 8'd2;
            for (int i = 0; i < afed_pkg::ADAS_FIELDS; i++)
            begin
                adas_prev_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                dsm_prev_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            mask_reg     <= mask_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    afed_pkg::CFG_ADAS_DEVICE: adas_code_reg <= cfg_data;
                    afed_pkg::CFG_DSM_DEVICE:  dsm_code_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (proc && close && adas_hit)
            begin
                for (int i = 0; i < afed_pkg::ADAS_FIELDS; i++)
                begin
                    adas_prev_reg[i] <= v[afed_pkg::ADAS_CI[i]];
                end
            end
            if (proc && close && (lite_hit || std_hit))
            begin
                dsm_prev_reg[0] <= v[afed_pkg::CI_B3];
            end
            if (proc && close && std_hit)
            begin
                dsm_prev_reg[1] <= v[afed_pkg::CI_B8];
                dsm_prev_reg[2] <= v[afed_pkg::CI_B29];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dev_reg <= dev_next;
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (proc)
        begin
            for (int i = 0; i < afed_pkg::CAP_N; i++)
            begin
                if (cnt_reg == CNT_W'(afed_pkg::CAP_POS[i]))
                begin
                    cap_reg[i] <= in_byte_reg;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/afed_checker.sv @@
// ----------------------------------------------------------------------------
// afed_checker
// Port-level checks on the event stream of the alarm frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module afed_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // stalled event holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("event changed while stalled");

    // event code in range and padding clear
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:8] != 4'd0) && (m_tdata[11:8] <= 4'd8)
                     && (m_tdata[15:12] == 4'd0))
        else $error("bad event code");

    // events of one frame follow back to back, ascending, same device
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid
            && (m_tdata[11:8] > $past(m_tdata[11:8]))
            && (m_tdata[7:0] == $past(m_tdata[7:0])))
        else $error("frame events out of order");

    // nothing pending right out of reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("event valid after reset");

endmodule

bind alarm_frame_edge_event_decoder afed_checker u_afed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/alarm_frame_edge_event_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_frame_edge_event_decoder_test
// Streams receive bursts into the decoder: camera-alarm, lite and standard
// driver-monitor frames, broken frames, noise and bursts that hit the length
// limit. A predictor tracks the previous alarm fields and device codes, and
// every event transaction is checked in order against it, under random
// gaps, random output stalls and one long output hold.
// ----------------------------------------------------------------------------

module alarm_frame_edge_event_decoder_test;

    import afed_pkg::*;

    localparam int BURST_LIMIT   = 128;
    localparam int CAPTURE_DEPTH = 46;
    localparam int DRAIN_SLACK   = 8;
    localparam int CYCLE_LIMIT   = 200000;

    localparam int CAM_POS [ADAS_FIELDS] = '{10, 11, 19, 20, 21, 22, 23};

    // slots of the driver-monitor previous fields
    localparam int DSM_B3  = 0;
    localparam int DSM_B8  = 1;
    localparam int DSM_B29 = 2;

    // event numbers beyond the per-field ones
    localparam logic [3:0] EV_CAM_B22      = 4'd6;
    localparam logic [3:0] EV_CAM_B23_ONE  = 4'd7;
    localparam logic [3:0] EV_CAM_B23_TWO  = 4'd8;
    localparam logic [3:0] EV_LITE_BIT5    = 4'd7;
    localparam logic [3:0] EV_LITE_BIT6    = 4'd8;
    localparam logic [3:0] EV_STD_B29_BIT0 = 4'd7;
    localparam logic [3:0] EV_STD_B29_BIT4 = 4'd8;

    typedef struct {
        logic [7:0] dev_code;
        logic [3:0] ev_code;
        logic       is_last;
    } alarm_event_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        s_tlast;   // burst_end
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] device_code, [11:8] event_code, [15:12] zero
    logic        m_tlast;   // last_event

    // predictor state
    logic [7:0]   captured [CAPTURE_DEPTH];
    int           open_len;
    logic [7:0]   cam_seen [ADAS_FIELDS];
    logic [7:0]   dsm_seen [3];
    logic [7:0]   cam_dev;
    logic [7:0]   dsm_dev;
    alarm_event_t expected_alarms [$];
    alarm_event_t want;

    logic [7:0] frame_buf [$];

    int  failures        = 0;
    int  events_checked  = 0;
    int  bytes_sent      = 0;
    int  camera_frames   = 0;
    int  lite_frames     = 0;
    int  standard_frames = 0;
    int  code_settings   = 1;
    int  cycle_count     = 0;

    // sender and receiver pacing
    bit  sender_steady   = 1'b0;
    int  burst_left      = 0;
    bit  receiver_steady = 1'b0;
    int  hold_request    = 0;
    int  hold_left       = 0;
    bit  rx_ready_phase  = 1'b0;
    int  rx_phase_left   = 0;

    alarm_frame_edge_event_decoder #(
        .BURST_LIMIT(BURST_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic bit rises(input logic [7:0] cur, input logic [7:0] old, input int b);
        return cur[b] && !old[b];
    endfunction

    // classify a closed burst and queue the events it raises
    task automatic decode_closed_frame(input int len);
        logic [7:0] dev;
        logic [3:0] codes [$];
        alarm_event_t ev;
        int i;
        dev = 8'h00;
        if (len == LEN_ADAS && captured[0] == HDR_START && captured[1] == ID_ADAS
                && captured[36] == TRL_ADAS)
        begin
            dev = cam_dev;
            for (i = 0; i < 5; i++)
                if (captured[CAM_POS[i]] == VAL_TWO && cam_seen[i] != VAL_TWO)
                    codes.push_back(4'(i + 1));
            if ((captured[22] == VAL_ONE || captured[22] == VAL_TWO) && cam_seen[5] == VAL_ZERO)
                codes.push_back(EV_CAM_B22);
            if (captured[23] == VAL_ONE && cam_seen[6] != VAL_ONE)
                codes.push_back(EV_CAM_B23_ONE);
            if (captured[23] == VAL_TWO && cam_seen[6] != VAL_TWO)
                codes.push_back(EV_CAM_B23_TWO);
            for (i = 0; i < ADAS_FIELDS; i++)
                cam_seen[i] = captured[CAM_POS[i]];
            camera_frames++;
        end
        else if (len == LEN_LITE && captured[0] == HDR_START && captured[1] == ID_DSM
                && captured[2] == ID_LITE && captured[4] == TRL_DSM)
        begin
            dev = dsm_dev;
            for (i = 0; i < 5; i++)
                if (rises(captured[3], dsm_seen[DSM_B3], i))
                    codes.push_back(4'(i + 1));
            if (rises(captured[3], dsm_seen[DSM_B3], 5))
                codes.push_back(EV_LITE_BIT5);
            if (rises(captured[3], dsm_seen[DSM_B3], 6))
                codes.push_back(EV_LITE_BIT6);
            dsm_seen[DSM_B3] = captured[3];
            lite_frames++;
        end
        else if (len >= LEN_STD_MIN && len < LEN_STD_END && captured[0] == HDR_START
                && captured[1] == ID_DSM && captured[45] == TRL_DSM)
        begin
            dev = dsm_dev;
            for (i = 0; i < 6; i++)
                if (rises(captured[8], dsm_seen[DSM_B8], i))
                    codes.push_back(4'(i + 1));
            if (rises(captured[29], dsm_seen[DSM_B29], 0))
                codes.push_back(EV_STD_B29_BIT0);
            if (rises(captured[29], dsm_seen[DSM_B29], 4))
                codes.push_back(EV_STD_B29_BIT4);
            dsm_seen[DSM_B3]  = captured[3];
            dsm_seen[DSM_B8]  = captured[8];
            dsm_seen[DSM_B29] = captured[29];
            standard_frames++;
        end
        for (i = 0; i < codes.size(); i++)
        begin
            ev.dev_code = dev;
            ev.ev_code  = codes[i];
            ev.is_last  = (i == codes.size() - 1);
            expected_alarms.push_back(ev);
        end
    endtask

    task automatic take_rx_byte(input logic [7:0] b, input logic last);
        int len;
        if (open_len < CAPTURE_DEPTH)
            captured[open_len] = b;
        if (open_len < BURST_LIMIT)
            open_len++;
        if (last || open_len >= BURST_LIMIT)
        begin
            len = open_len;
            open_len = 0;
            decode_closed_frame(len);
        end
    endtask

    // one input transaction; called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!sender_steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        take_rx_byte(b, last);
        @(negedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic fill_random(input int len);
        int i;
        frame_buf.delete();
        for (i = 0; i < len; i++)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_camera(input logic [7:0] f10, f11, f19, f20, f21, f22, f23);
        fill_random(LEN_ADAS);
        frame_buf[0]  = HDR_START;
        frame_buf[1]  = ID_ADAS;
        frame_buf[10] = f10;
        frame_buf[11] = f11;
        frame_buf[19] = f19;
        frame_buf[20] = f20;
        frame_buf[21] = f21;
        frame_buf[22] = f22;
        frame_buf[23] = f23;
        frame_buf[36] = TRL_ADAS;
    endtask

    task automatic build_lite(input logic [7:0] b3);
        fill_random(LEN_LITE);
        frame_buf[0] = HDR_START;
        frame_buf[1] = ID_DSM;
        frame_buf[2] = ID_LITE;
        frame_buf[3] = b3;
        frame_buf[4] = TRL_DSM;
    endtask

    task automatic build_standard(input int len, input logic [7:0] b3, b8, b29);
        fill_random(len);
        frame_buf[0]  = HDR_START;
        frame_buf[1]  = ID_DSM;
        frame_buf[3]  = b3;
        frame_buf[8]  = b8;
        frame_buf[29] = b29;
        frame_buf[45] = TRL_DSM;
    endtask

    function automatic logic [7:0] cam_level();
        case ($urandom_range(0, 5))
            0, 1:    return VAL_ZERO;
            2:       return VAL_ONE;
            3, 4:    return VAL_TWO;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic build_random_camera();
        build_camera(cam_level(), cam_level(), cam_level(), cam_level(), cam_level(),
                     cam_level(), cam_level());
    endtask

    // pause the sender until every queued event has been taken
    task automatic wait_for_events();
        s_tvalid <= 1'b0;
        while (expected_alarms.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    // only while idle; both writes land on consecutive edges
    task automatic set_device_codes(input logic [7:0] cam_code, input logic [7:0] dsm_code);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ADAS_DEVICE;
        cfg_data  <= cam_code;
        @(posedge clk);
        cam_dev = cam_code;
        @(negedge clk);
        cfg_index <= CFG_DSM_DEVICE;
        cfg_data  <= dsm_code;
        @(posedge clk);
        dsm_dev = dsm_code;
        @(negedge clk);
        cfg_we <= 1'b0;
        code_settings++;
    endtask

    task automatic test_camera_alarms();
        build_camera(VAL_TWO, VAL_TWO, VAL_TWO, VAL_TWO, VAL_TWO, VAL_ONE, VAL_ONE);
        send_frame();
        // b22 only fires from zero, b23 moves from one to two
        build_camera(VAL_TWO, VAL_TWO, VAL_TWO, VAL_TWO, VAL_TWO, VAL_TWO, VAL_TWO);
        send_frame();
        wait_for_events();
    endtask

    task automatic test_lite_monitor();
        build_lite(8'hff);
        send_frame();
        build_lite(8'h80);
        send_frame();
        build_lite(8'h55);
        send_frame();
        wait_for_events();
    endtask

    task automatic test_standard_monitor();
        build_standard(LEN_STD_MIN, 8'h7f, 8'h3f, 8'h11);
        send_frame();
        // standard frame already stored b3, so nothing rises here
        build_lite(8'h7f);
        send_frame();
        wait_for_events();
    endtask

    task automatic test_malformed_frames();
        build_lite(8'h00);
        send_frame();
        // none of these may raise an event or touch the stored fields
        build_lite(8'h7f);
        void'(frame_buf.pop_back());
        send_frame();
        build_lite(8'h7f);
        frame_buf.push_back(TRL_DSM);
        send_frame();
        build_lite(8'h7f);
        frame_buf[2] = ID_ADAS;
        send_frame();
        // valid frame again: events show the stored field was kept
        build_lite(8'h1f);
        send_frame();
        wait_for_events();
    endtask

    task automatic test_burst_limit();
        int i;
        // standard header, but the burst runs into the limit
        build_standard(LEN_STD_MIN, 8'h00, 8'h00, 8'h00);
        for (i = 0; i < BURST_LIMIT; i++)
            send_byte(i < LEN_STD_MIN ? frame_buf[i] : 8'($urandom_range(0, 255)), 1'b0);
        // limit closed the burst, so this one starts clean
        build_lite(8'h60);
        send_frame();
        wait_for_events();
    endtask

    task automatic test_output_backpressure();
        int i;
        sender_steady = 1'b1;
        hold_request = 400;
        for (i = 0; i < 4; i++)
        begin
            build_lite(i % 2 == 0 ? 8'h7f : 8'h00);
            send_frame();
        end
        sender_steady = 1'b0;
        wait_for_events();
    endtask

    task automatic send_random_frame();
        int pick;
        int len;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            build_lite(8'($urandom_range(0, 255)));
        else if (pick < 50)
            build_random_camera();
        else if (pick < 70)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(LEN_STD_MIN, LEN_STD_END - 1)
                                              : $urandom_range(LEN_STD_MIN, LEN_STD_MIN + 4);
            build_standard(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 2))
                0:       build_lite(8'($urandom_range(0, 255)));
                1:       build_random_camera();
                default: build_standard(LEN_STD_MIN, 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 4))
                0:       frame_buf[0] ^= 8'(1 << $urandom_range(0, 7));
                1:       frame_buf[1] ^= 8'(1 << $urandom_range(0, 7));
                2:       frame_buf[frame_buf.size() - 1] ^= 8'($urandom_range(1, 255));
                3:       void'(frame_buf.pop_back());
                default: frame_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        else
        begin
            fill_random($urandom_range(1, 12));
            if ($urandom_range(0, 1) == 1)
                frame_buf[0] = HDR_START;
        end
        send_frame();
    endtask

    task automatic test_random_traffic();
        int phase;
        int start;
        for (phase = 0; phase < 2; phase++)
        begin
            case (phase)
                0:       set_device_codes(8'h00, 8'hff);
                default: set_device_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            sender_steady   = (phase == 1);
            receiver_steady = (phase == 1);
            start = bytes_sent;
            while (bytes_sent - start < 30)
                send_random_frame();
            wait_for_events();
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // output side: random or steady ready pattern, plus a long hold on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (receiver_steady)
                m_tready <= 1'b1;
            else
            begin
                if (rx_phase_left == 0)
                begin
                    rx_ready_phase = !rx_ready_phase;
                    rx_phase_left = rx_ready_phase ? $urandom_range(1, 24) : $urandom_range(1, 5);
                end
                rx_phase_left--;
                m_tready <= rx_ready_phase;
            end
        end
    end

    // every event transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_alarms.size() == 0)
            begin
                $error("event with none expected: device_code %0d, event_code %0d",
                       m_tdata[7:0], m_tdata[11:8]);
                failures++;
            end
            else
            begin
                want = expected_alarms.pop_front();
                events_checked++;
                if (m_tdata[7:0] !== want.dev_code)
                begin
                    $error("device_code: expected %0d, actual %0d", want.dev_code, m_tdata[7:0]);
                    failures++;
                end
                if (m_tdata[11:8] !== want.ev_code)
                begin
                    $error("event_code: expected %0d, actual %0d", want.ev_code, m_tdata[11:8]);
                    failures++;
                end
                if (m_tlast !== want.is_last)
                begin
                    $error("last_event: expected %0d, actual %0d", want.is_last, m_tlast);
                    failures++;
                end
                if (m_tdata[15:12] !== 4'd0)
                begin
                    $error("tdata padding: expected 0, actual %0h", m_tdata[15:12]);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int waited;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ADAS_DEVICE;
        cfg_data  = 8'h00;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        open_len  = 0;
        cam_dev   = 8'd1;
        dsm_dev   = 8'd2;
        foreach (captured[i])
            captured[i] = 8'h00;
        foreach (cam_seen[i])
            cam_seen[i] = 8'h00;
        foreach (dsm_seen[i])
            dsm_seen[i] = 8'h00;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_camera_alarms();
        test_lite_monitor();
        test_standard_monitor();
        test_malformed_frames();
        test_burst_limit();
        test_output_backpressure();
        test_random_traffic();

        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_alarms.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4 * DRAIN_SLACK) @(negedge clk);
        if (expected_alarms.size() != 0)
        begin
            $error("%0d expected events never arrived", expected_alarms.size());
            failures++;
        end

        $display("sent %0d bytes: %0d camera, %0d lite and %0d standard frames decoded",
                 bytes_sent, camera_frames, lite_frames, standard_frames);
        $display("checked %0d alarm events over %0d device code settings",
                 events_checked, code_settings);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
